// ===== rtl/vertex_affine_transform_defines.svh =====
// Assertion macros shared by the vertex transform RTL.
// Needs a clk and an active-low rst_n in the scope of each use.
`ifndef VERTEX_AFFINE_TRANSFORM_DEFINES_SVH
`define VERTEX_AFFINE_TRANSFORM_DEFINES_SVH

// same-cycle implication
`define VAT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define VAT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/vat_pkg.sv =====
// Types, command codes and the quarter-wave sine builder for the vertex transform.
// No dependencies.
`timescale 1ns / 1ps

package vat_pkg;

  typedef logic [2:0]          cmd_t;
  typedef logic [1:0]          axis_t;
  typedef logic signed [31:0]  coord_t;
  typedef logic signed [32:0]  tdelta_t;
  typedef logic signed [33:0]  direct_t;
  typedef logic [15:0]         angle_t;
  typedef logic [16:0]         sine_t;
  typedef logic signed [17:0]  trig_t;
  typedef logic signed [49:0]  prod_b_t;
  typedef logic signed [63:0]  prod_a_t;
  typedef logic signed [64:0]  sum_t;
  typedef logic signed [48:0]  value_t;

  localparam cmd_t CMD_TX = 3'd0;
  localparam cmd_t CMD_TY = 3'd1;
  localparam cmd_t CMD_TZ = 3'd2;
  localparam cmd_t CMD_RX = 3'd3;
  localparam cmd_t CMD_RY = 3'd4;
  localparam cmd_t CMD_RZ = 3'd5;
  localparam cmd_t CMD_SC = 3'd6;
  localparam cmd_t CMD_NOP = 3'd7;

  localparam axis_t AXIS_X = 2'd0;
  localparam axis_t AXIS_Y = 2'd1;
  localparam axis_t AXIS_Z = 2'd2;

  localparam int    PHASE_BITS = 14;
  localparam sine_t SINE_ONE   = 17'h10000;
  localparam sum_t  ROUND_HALF = 65'sd32768;
  localparam longint Q30_ONE   = 64'sd1073741824;

  // Entry idx of a quarter sine with 2^bits steps, Q1.16, odd degree-9 polynomial.
  // Only evaluated at elaboration with constant arguments.
  function automatic sine_t quarter_sine(input int idx, input int bits);
    longint n;
    longint x;
    longint x2;
    longint t;
    longint s;
    n = longint'(1) << bits;
    if (longint'(idx) >= n) begin
      return SINE_ONE;
    end
    x  = longint'(idx) << (30 - bits);
    x2 = (x * x) / Q30_ONE;
    t  = 172272;
    t  = -5026995 + (t * x2) / Q30_ONE;
    t  = 85569306 + (t * x2) / Q30_ONE;
    t  = -693598670 + (t * x2) / Q30_ONE;
    t  = 1686629713 + (t * x2) / Q30_ONE;
    s  = (t * x) / Q30_ONE;
    if (s < 0) begin
      s = 0;
    end
    s = (s + 8192) / 16384;
    if (s > 65536) begin
      s = 65536;
    end
    return sine_t'(s);
  endfunction

endpackage

// ===== rtl/vertex_affine_transform.sv =====
// Vertex translate / rotate / scale, four registers deep: input stage, sine lookup,
// products, rounded and saturated result; out_valid follows the beat through all four.
// One vertex per cycle sustained while out_stall is low; any bubble lets a new beat in.
// Stored offsets and angles update as a pass-end beat is taken, so the next beat sees them.
// Synchronous active-low reset clears all stage valids, offsets and angles.
`timescale 1ns / 1ps
`include "vertex_affine_transform_defines.svh"

module vertex_affine_transform #(
  parameter int SINE_TABLE_BITS = 10,
  parameter int COORD_WIDTH     = 32
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  vat_pkg::cmd_t   in_cmd,
  input  vat_pkg::coord_t in_amount,
  input  vat_pkg::coord_t in_vert_x,
  input  vat_pkg::coord_t in_vert_y,
  input  vat_pkg::coord_t in_vert_z,
  input  logic            in_pass_end,
  output logic            out_valid,
  input  logic            out_stall,
  output vat_pkg::coord_t out_res_x,
  output vat_pkg::coord_t out_res_y,
  output vat_pkg::coord_t out_res_z,
  output logic            out_res_end,
  output logic            out_clipped
);

  import vat_pkg::*;

  localparam int TBL_AW    = SINE_TABLE_BITS + 1;
  localparam int TBL_DEPTH = (1 << SINE_TABLE_BITS) + 1;
  localparam int SAT_W     = (COORD_WIDTH > 32) ? 32 : COORD_WIDTH;
  localparam logic [TBL_AW-1:0] TBL_N = TBL_AW'(1) << SINE_TABLE_BITS;
  localparam value_t SAT_HI = (value_t'(1) <<< (SAT_W - 1)) - value_t'(1);
  localparam value_t SAT_LO = -SAT_HI - value_t'(1);
  localparam coord_t SAT_HI32 = coord_t'(SAT_HI);
  localparam coord_t SAT_LO32 = coord_t'(SAT_LO);

  // quarter-wave table, constant
  sine_t sine_rom [TBL_DEPTH];
  for (genvar gi = 0; gi < TBL_DEPTH; gi++) begin : g_rom
    assign sine_rom[gi] = quarter_sine(gi, SINE_TABLE_BITS);
  end

  // ---------------- handshake chain ----------------
  logic s1_valid_r, s2_valid_r, s3_valid_r, out_valid_r;
  logic s1_adv, s2_adv, s3_adv, out_adv, in_acc;

  assign out_adv  = !out_valid_r || !out_stall;
  assign s3_adv   = !s3_valid_r || out_adv;
  assign s2_adv   = !s2_valid_r || s3_adv;
  assign s1_adv   = !s1_valid_r || s2_adv;
  assign in_stall = !s1_adv;
  assign in_acc   = in_valid && s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_adv)  s1_valid_r  <= in_acc;
      if (s2_adv)  s2_valid_r  <= s1_valid_r;
      if (s3_adv)  s3_valid_r  <= s2_valid_r;
      if (out_adv) out_valid_r <= s3_valid_r;
    end
  end

  // ---------------- stored offsets and angles ----------------
  coord_t off_r [3];
  angle_t ang_r [3];
  axis_t  ax;
  logic   is_trans, is_rot;

  always_comb begin
    ax       = AXIS_X;
    is_trans = 1'b0;
    is_rot   = 1'b0;
    unique case (in_cmd)
      CMD_TX: begin ax = AXIS_X; is_trans = 1'b1; end
      CMD_TY: begin ax = AXIS_Y; is_trans = 1'b1; end
      CMD_TZ: begin ax = AXIS_Z; is_trans = 1'b1; end
      CMD_RX: begin ax = AXIS_X; is_rot = 1'b1; end
      CMD_RY: begin ax = AXIS_Y; is_rot = 1'b1; end
      CMD_RZ: begin ax = AXIS_Z; is_rot = 1'b1; end
      CMD_SC, CMD_NOP: begin ax = AXIS_X; end
      default: begin ax = AXIS_X; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        off_r[i] <= '0;
        ang_r[i] <= '0;
      end
    end else if (in_acc && in_pass_end) begin
      if (is_trans) off_r[ax] <= in_amount;
      if (is_rot)   ang_r[ax] <= in_amount[15:0];
    end
  end

  // ---------------- stage 1: deltas and table addresses ----------------
  tdelta_t tdelta_nxt;
  angle_t  adelta_nxt;
  logic [TBL_AW-1:0] idx_a_nxt;

  assign tdelta_nxt = tdelta_t'(in_amount) - tdelta_t'(off_r[ax]);
  assign adelta_nxt = in_amount[15:0] - ang_r[ax];
  assign idx_a_nxt  = TBL_AW'(adelta_nxt[PHASE_BITS-1 -: SINE_TABLE_BITS]);

  cmd_t    s1_cmd_r;
  coord_t  s1_amount_r;
  coord_t  s1_vert_r [3];
  logic    s1_end_r;
  tdelta_t s1_tdelta_r;
  logic [1:0] s1_quad_r;
  logic [TBL_AW-1:0] s1_idx_a_r, s1_idx_b_r;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_cmd_r     <= in_cmd;
      s1_amount_r  <= in_amount;
      s1_vert_r[0] <= in_vert_x;
      s1_vert_r[1] <= in_vert_y;
      s1_vert_r[2] <= in_vert_z;
      s1_end_r     <= in_pass_end;
      s1_tdelta_r  <= tdelta_nxt;
      s1_quad_r    <= adelta_nxt[15:14];
      s1_idx_a_r   <= idx_a_nxt;
      s1_idx_b_r   <= TBL_N - idx_a_nxt;
    end
  end

  // ---------------- stage 2: sine / cosine ----------------
  trig_t ta, tb, sin_nxt, cos_nxt;

  always_comb begin
    ta = trig_t'({1'b0, sine_rom[s1_idx_a_r]});
    tb = trig_t'({1'b0, sine_rom[s1_idx_b_r]});
    unique case (s1_quad_r)
      2'd0: begin sin_nxt = ta;  cos_nxt = tb;  end
      2'd1: begin sin_nxt = tb;  cos_nxt = -ta; end
      2'd2: begin sin_nxt = -ta; cos_nxt = -tb; end
      2'd3: begin sin_nxt = -tb; cos_nxt = ta;  end
      default: begin sin_nxt = ta; cos_nxt = tb; end
    endcase
  end

  cmd_t    s2_cmd_r;
  coord_t  s2_amount_r;
  coord_t  s2_vert_r [3];
  logic    s2_end_r;
  tdelta_t s2_tdelta_r;
  trig_t   s2_sin_r, s2_cos_r;

  always_ff @(posedge clk) begin
    if (s2_adv && s1_valid_r) begin
      s2_cmd_r    <= s1_cmd_r;
      s2_amount_r <= s1_amount_r;
      s2_vert_r   <= s1_vert_r;
      s2_end_r    <= s1_end_r;
      s2_tdelta_r <= s1_tdelta_r;
      s2_sin_r    <= sin_nxt;
      s2_cos_r    <= cos_nxt;
    end
  end

  // ---------------- stage 3: operand select and products ----------------
  // each lane is ka*ca + kb*cb, or a direct value for pass/translate lanes
  coord_t  ka [3];
  coord_t  ca [3];
  trig_t   kb [3];
  coord_t  cb [3];
  logic    use_mul_nxt [3];
  direct_t direct_nxt [3];
  coord_t  sin32, cos32;
  trig_t   nsin;

  always_comb begin
    sin32 = coord_t'(s2_sin_r);
    cos32 = coord_t'(s2_cos_r);
    nsin  = -s2_sin_r;
    for (int i = 0; i < 3; i++) begin
      ka[i]          = '0;
      ca[i]          = '0;
      kb[i]          = '0;
      cb[i]          = '0;
      use_mul_nxt[i] = 1'b0;
      direct_nxt[i]  = direct_t'(s2_vert_r[i]);
    end
    unique case (s2_cmd_r)
      CMD_TX: direct_nxt[0] = direct_t'(s2_vert_r[0]) + direct_t'(s2_tdelta_r);
      CMD_TY: direct_nxt[1] = direct_t'(s2_vert_r[1]) + direct_t'(s2_tdelta_r);
      CMD_TZ: direct_nxt[2] = direct_t'(s2_vert_r[2]) + direct_t'(s2_tdelta_r);
      CMD_RX: begin
        use_mul_nxt[1] = 1'b1;
        ka[1] = cos32; ca[1] = s2_vert_r[1]; kb[1] = nsin;     cb[1] = s2_vert_r[2];
        use_mul_nxt[2] = 1'b1;
        ka[2] = sin32; ca[2] = s2_vert_r[1]; kb[2] = s2_cos_r; cb[2] = s2_vert_r[2];
      end
      CMD_RY: begin
        use_mul_nxt[0] = 1'b1;
        ka[0] = cos32; ca[0] = s2_vert_r[0]; kb[0] = s2_sin_r; cb[0] = s2_vert_r[2];
        use_mul_nxt[2] = 1'b1;
        ka[2] = cos32; ca[2] = s2_vert_r[2]; kb[2] = nsin;     cb[2] = s2_vert_r[0];
      end
      CMD_RZ: begin
        use_mul_nxt[0] = 1'b1;
        ka[0] = cos32; ca[0] = s2_vert_r[0]; kb[0] = nsin;     cb[0] = s2_vert_r[1];
        use_mul_nxt[1] = 1'b1;
        ka[1] = sin32; ca[1] = s2_vert_r[0]; kb[1] = s2_cos_r; cb[1] = s2_vert_r[1];
      end
      CMD_SC: begin
        for (int i = 0; i < 3; i++) begin
          use_mul_nxt[i] = 1'b1;
          ka[i] = s2_amount_r;
          ca[i] = s2_vert_r[i];
        end
      end
      CMD_NOP: begin
        use_mul_nxt[0] = 1'b0;
      end
      default: begin
        use_mul_nxt[0] = 1'b0;
      end
    endcase
  end

  prod_a_t s3_prod_a_r [3];
  prod_b_t s3_prod_b_r [3];
  logic    s3_use_mul_r [3];
  direct_t s3_direct_r [3];
  logic    s3_end_r;

  always_ff @(posedge clk) begin
    if (s3_adv && s2_valid_r) begin
      for (int i = 0; i < 3; i++) begin
        s3_prod_a_r[i]  <= prod_a_t'(ka[i]) * prod_a_t'(ca[i]);
        s3_prod_b_r[i]  <= prod_b_t'(kb[i]) * prod_b_t'(cb[i]);
        s3_use_mul_r[i] <= use_mul_nxt[i];
        s3_direct_r[i]  <= direct_nxt[i];
      end
      s3_end_r <= s2_end_r;
    end
  end

  // ---------------- output stage: round, saturate ----------------
  sum_t   lane_sum [3];
  value_t lane_val [3];
  coord_t res_nxt [3];
  logic   clip_nxt;

  always_comb begin
    clip_nxt = 1'b0;
    for (int i = 0; i < 3; i++) begin
      lane_sum[i] = sum_t'(s3_prod_a_r[i]) + sum_t'(s3_prod_b_r[i]) + ROUND_HALF;
      lane_val[i] = s3_use_mul_r[i] ? value_t'(lane_sum[i] >>> 16)
                                    : value_t'(s3_direct_r[i]);
      if (lane_val[i] > SAT_HI) begin
        res_nxt[i] = SAT_HI32;
        clip_nxt   = 1'b1;
      end else if (lane_val[i] < SAT_LO) begin
        res_nxt[i] = SAT_LO32;
        clip_nxt   = 1'b1;
      end else begin
        res_nxt[i] = coord_t'(lane_val[i]);
      end
    end
  end

  coord_t res_r [3];
  logic   res_end_r, clip_r;

  always_ff @(posedge clk) begin
    if (out_adv && s3_valid_r) begin
      res_r     <= res_nxt;
      res_end_r <= s3_end_r;
      clip_r    <= clip_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_res_x   = res_r[0];
  assign out_res_y   = res_r[1];
  assign out_res_z   = res_r[2];
  assign out_res_end = res_end_r;
  assign out_clipped = clip_r;

  // ---------------- checks ----------------
  `VAT_ASSERT_NEXT(a_offset_commit, in_acc && is_trans && in_pass_end, off_r[$past(ax)] == $past(in_amount), "offset not committed on pass end")
  `VAT_ASSERT_NEXT(a_angle_commit, in_acc && is_rot && in_pass_end, ang_r[$past(ax)] == $past(in_amount[15:0]), "angle not committed on pass end")
  `VAT_ASSERT_NOW(a_clip_at_bound, out_valid_r && clip_r, res_r[0] == SAT_HI32 || res_r[0] == SAT_LO32 || res_r[1] == SAT_HI32 || res_r[1] == SAT_LO32 || res_r[2] == SAT_HI32 || res_r[2] == SAT_LO32, "clip flag without a saturated coordinate")
  `VAT_ASSERT_NOW(a_front_bubble, !s1_valid_r, !in_stall, "input stalled with empty front stage")

endmodule
